@@ src/fac_pkg.sv @@
// fac_pkg.sv: shared types, constants and codes of the fit allocator
`timescale 1ns / 1ps
package fac_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int USED_ENTRIES = 16;
  localparam int ID_BITS      = 8;
  localparam int RST_REGIONS  = 5;

  localparam logic [23:0] MIB = 24'(1024 * 1024);
  localparam logic [24:0] MERGE_LIMIT_RST = 25'(4 * 1024 * 1024);

  // reset free regions: 1,1,1,2,8 MiB from 3 MiB
  localparam logic [23:0] RST_START [RST_REGIONS] = '{
    24'(3 * 1024 * 1024), 24'(4 * 1024 * 1024), 24'(5 * 1024 * 1024),
    24'(6 * 1024 * 1024), 24'(8 * 1024 * 1024)};
  localparam logic [23:0] RST_LEN [RST_REGIONS] = '{
    24'(1024 * 1024), 24'(1024 * 1024), 24'(1024 * 1024),
    24'(2 * 1024 * 1024), 24'(8 * 1024 * 1024)};

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TERM  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    CFG_FIT_MODE    = 1'b0,
    CFG_MERGE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  owner_id;
    logic [7:0]  block_tag;
    logic [24:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] granted_address;
    logic [24:0] freed_bytes;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_A_SCAN, S_A_END, S_A_WRITE, S_F_SCAN, S_F_CHK,
    S_I_SCAN, S_T_CNT, S_T_CHK, S_T_LOOP, S_M_START, S_M_LOAD, S_M_STEP,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    C_NOP, C_LOAD, C_ASTART, C_ASCAN, C_APICK, C_AWRITE, C_STATUS,
    C_USTART, C_USKIP, C_TCNT, C_TAKE, C_FSKIP, C_IWRITE, C_MSTART,
    C_MLOAD, C_MSTEP, C_OUT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic req_zero;
    logic fit_mode;
    logic f_end;     // free index at fill count
    logic u_end;     // used index at fill count
    logic fit;       // current free entry holds the request
    logic pick_ok;
    logic u_match;   // owner and tag match
    logic o_match;   // owner matches
    logic ufull;
    logic ffull;
    logic k_zero;
    logic t_over;    // free table lacks room for all owner regions
    logic ins_here;  // current free entry starts above the region to insert
    logic m_end;     // no successor left in this merge pass
    logic changed;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/fit_allocator_with_coalesce_unit.sv @@
// fit_allocator_with_coalesce_unit.sv: top level of the fit allocator
//
//  channel | signals                              | accepted when
//  --------+--------------------------------------+------------------------
//  input   | in_valid, in_ready, in_item          | in_valid && in_ready
//  result  | out_valid, out_ready, out_item       | out_valid && out_ready
//  config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
//  one item at a time; an allocate scans the free table, a free or terminate
//  scans the used table, then does a free-table insert scan per region and
//  then merge passes, all walked by the sequencer over the single read port
//  of the free table
//  reset loads the five initial free regions at once, no clearing pass
//  a result waits in the output register; the next item is taken only in the
//  idle state, so a stalled result holds the unit in its done state
`timescale 1ns / 1ps
module fit_allocator_with_coalesce_unit #(
  parameter int FREE_ENTRIES = fac_pkg::FREE_ENTRIES,
  parameter int USED_ENTRIES = fac_pkg::USED_ENTRIES,
  parameter int ID_BITS      = fac_pkg::ID_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fac_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fac_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [24:0]        cfg_data
);

  fac_pkg::cmd_t     cmd;
  fac_pkg::dp_stat_t stat;

  // config writes are always taken; they only land while idle by contract
  assign cfg_ready = 1'b1;

  fac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fac_dp #(
    .F   (FREE_ENTRIES),
    .U   (USED_ENTRIES),
    .IDB (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ src/fac_dp.sv @@
// fac_dp.sv: free and used tables, item registers, config and result register
`timescale 1ns / 1ps
module fac_dp #(
  parameter int F   = fac_pkg::FREE_ENTRIES,
  parameter int U   = fac_pkg::USED_ENTRIES,
  parameter int IDB = fac_pkg::ID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [24:0]         cfg_data,
  input  fac_pkg::in_item_t   in_item,
  input  logic                out_ready,
  output logic                out_valid,
  output fac_pkg::out_item_t  out_item,
  input  fac_pkg::cmd_t       cmd,
  output fac_pkg::dp_stat_t   stat
);

  localparam int FIW = $clog2(F);
  localparam int FCW = $clog2(F + 1);
  localparam int UIW = (U > 1) ? $clog2(U) : 1;
  localparam int UCW = $clog2(U + 1);
  localparam int KW  = ((FCW > UCW) ? FCW : UCW) + 1;

  logic [23:0]    fs [F];
  logic [23:0]    fl [F];
  logic [FCW-1:0] fcnt, fi, pick;
  logic [23:0]    us [U];
  logic [23:0]    ul [U];
  logic [IDB-1:0] uo [U];
  logic [IDB-1:0] ut [U];
  logic [UCW-1:0] ucnt, ui, kcnt;

  logic           fit_mode;
  logic [24:0]    merge_limit;
  logic [1:0]     op;
  logic [IDB-1:0] own, tag;
  logic [24:0]    req;
  logic           pick_ok, changed;
  logic [23:0]    plen, ins_s, ins_l, cur_s, cur_l;
  logic [1:0]     status;
  logic [23:0]    granted;
  logic [24:0]    freed;

  logic [FCW-1:0] rsel;
  logic [FIW-1:0] rd_idx;
  logic [UIW-1:0] ui_idx, uw_idx;
  logic [23:0]    rs, rl, u_s, u_l;
  logic [24:0]    cur_end, msum;
  logic           m_cond, a_empty;
  logic [KW-1:0]  ksum;

  // single read port on the free table; the merge step looks one entry ahead
  assign rsel   = (cmd.op == fac_pkg::C_MSTEP) ? fi + FCW'(1) : fi;
  assign rd_idx = rsel[FIW-1:0];
  assign rs     = fs[rd_idx];
  assign rl     = fl[rd_idx];
  assign ui_idx = ui[UIW-1:0];
  assign uw_idx = ucnt[UIW-1:0];
  assign u_s    = us[ui_idx];
  assign u_l    = ul[ui_idx];

  assign cur_end = {1'b0, cur_s} + {1'b0, cur_l};
  assign msum    = {1'b0, cur_l} + {1'b0, rl};
  assign m_cond  = (cur_end == {1'b0, rs}) && (msum < merge_limit) && !msum[24];
  assign a_empty = (rl == req[23:0]);
  assign ksum    = KW'(fcnt) + KW'(kcnt);

  always_comb begin
    stat.op       = fac_pkg::op_t'(op);
    stat.req_zero = (req == 25'd0);
    stat.fit_mode = fit_mode;
    stat.f_end    = (fi == fcnt);
    stat.u_end    = (ui == ucnt);
    stat.fit      = ({1'b0, rl} >= req);
    stat.pick_ok  = pick_ok;
    stat.u_match  = (uo[ui_idx] == own) && (ut[ui_idx] == tag);
    stat.o_match  = (uo[ui_idx] == own);
    stat.ufull    = (ucnt == UCW'(U));
    stat.ffull    = (fcnt == FCW'(F));
    stat.k_zero   = (kcnt == '0);
    stat.t_over   = (ksum > KW'(F));
    stat.ins_here = (rs > ins_s);
    stat.m_end    = ((KW'(fi) + KW'(1)) >= KW'(fcnt));
    stat.changed  = changed;
    stat.out_free = !out_valid || out_ready;
  end

  // free table, reset to the five initial regions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < F; j++) begin
        fs[j] <= (j < fac_pkg::RST_REGIONS) ? fac_pkg::RST_START[j] : '0;
        fl[j] <= (j < fac_pkg::RST_REGIONS) ? fac_pkg::RST_LEN[j] : '0;
      end
      fcnt <= FCW'(fac_pkg::RST_REGIONS);
    end else begin
      case (cmd.op)
        fac_pkg::C_AWRITE: begin
          for (int j = 0; j < F; j++) begin
            if (a_empty && FCW'(j) >= fi) begin
              fs[j] <= (j < F - 1) ? fs[(j < F - 1) ? j + 1 : j] : '0;
              fl[j] <= (j < F - 1) ? fl[(j < F - 1) ? j + 1 : j] : '0;
            end else if (!a_empty && FCW'(j) == fi) begin
              fs[j] <= rs + req[23:0];
              fl[j] <= rl - req[23:0];
            end
          end
          if (a_empty) fcnt <= fcnt - FCW'(1);
        end
        fac_pkg::C_IWRITE: begin
          for (int j = 0; j < F; j++) begin
            if (FCW'(j) == fi) begin
              fs[j] <= ins_s;
              fl[j] <= ins_l;
            end else if (FCW'(j) > fi) begin
              fs[j] <= fs[(j > 0) ? j - 1 : 0];
              fl[j] <= fl[(j > 0) ? j - 1 : 0];
            end
          end
          fcnt <= fcnt + FCW'(1);
        end
        fac_pkg::C_MSTEP: begin
          if (m_cond) begin
            for (int j = 0; j < F; j++) begin
              if (FCW'(j) == fi) begin
                fl[j] <= msum[23:0];
              end else if (FCW'(j) > fi) begin
                fs[j] <= (j < F - 1) ? fs[(j < F - 1) ? j + 1 : j] : '0;
                fl[j] <= (j < F - 1) ? fl[(j < F - 1) ? j + 1 : j] : '0;
              end
            end
            fcnt <= fcnt - FCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // used table payload, undefined until written
  always_ff @(posedge clk) begin
    case (cmd.op)
      fac_pkg::C_AWRITE: begin
        us[uw_idx] <= rs;
        ul[uw_idx] <= req[23:0];
        uo[uw_idx] <= own;
        ut[uw_idx] <= tag;
      end
      fac_pkg::C_TAKE: begin
        for (int j = 0; j < U - 1; j++) begin
          if (UCW'(j) >= ui) begin
            us[j] <= us[j + 1];
            ul[j] <= ul[j + 1];
            uo[j] <= uo[j + 1];
            ut[j] <= ut[j + 1];
          end
        end
      end
      default: ;
    endcase
  end

  // item registers, scan state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      ucnt        <= '0;
      fit_mode    <= 1'b0;
      merge_limit <= fac_pkg::MERGE_LIMIT_RST;
      out_valid   <= 1'b0;
      pick_ok     <= 1'b0;
      changed     <= 1'b0;
      fi          <= '0;
      ui          <= '0;
      kcnt        <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (fac_pkg::cfg_reg_t'(cfg_index))
          fac_pkg::CFG_FIT_MODE:    fit_mode <= cfg_data[0];
          fac_pkg::CFG_MERGE_LIMIT: merge_limit <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && cmd.op != fac_pkg::C_OUT) out_valid <= 1'b0;
      case (cmd.op)
        fac_pkg::C_LOAD: begin
          op         <= in_item.operation;
          own        <= IDB'(in_item.owner_id);
          tag        <= IDB'(in_item.block_tag);
          req        <= in_item.request_bytes;
          status     <= fac_pkg::ST_OK;
          granted    <= '0;
          freed      <= '0;
        end
        fac_pkg::C_ASTART: begin
          fi      <= '0;
          pick_ok <= 1'b0;
        end
        fac_pkg::C_ASCAN: begin
          if (stat.fit && (!pick_ok || rl < plen)) begin
            pick    <= fi;
            plen    <= rl;
            pick_ok <= 1'b1;
          end
          fi <= fi + FCW'(1);
        end
        fac_pkg::C_APICK:  fi <= pick;
        fac_pkg::C_AWRITE: begin
          granted <= rs;
          ucnt    <= ucnt + UCW'(1);
        end
        fac_pkg::C_STATUS: status <= cmd.code;
        fac_pkg::C_USTART: begin
          ui   <= '0;
          kcnt <= '0;
        end
        fac_pkg::C_USKIP: ui <= ui + UCW'(1);
        fac_pkg::C_TCNT: begin
          if (stat.o_match) kcnt <= kcnt + UCW'(1);
          ui <= ui + UCW'(1);
        end
        fac_pkg::C_TAKE: begin
          ins_s <= u_s;
          ins_l <= u_l;
          freed <= freed + {1'b0, u_l};
          ucnt  <= ucnt - UCW'(1);
          fi    <= '0;
        end
        fac_pkg::C_FSKIP: fi <= fi + FCW'(1);
        fac_pkg::C_MSTART: begin
          fi      <= '0;
          changed <= 1'b0;
        end
        fac_pkg::C_MLOAD: begin
          cur_s <= rs;
          cur_l <= rl;
        end
        fac_pkg::C_MSTEP: begin
          if (m_cond) changed <= 1'b1;
          fi <= fi + FCW'(1);
        end
        fac_pkg::C_OUT: begin
          out_valid                <= 1'b1;
          out_item.status          <= status;
          out_item.granted_address <= granted;
          out_item.freed_bytes     <= freed;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/fac_ctrl.sv @@
// fac_ctrl.sv: sequencer that steps the datapath through each operation
`timescale 1ns / 1ps
module fac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fac_pkg::dp_stat_t stat,
  output fac_pkg::cmd_t     cmd
);

  fac_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= fac_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fac_pkg::S_IDLE:     if (in_valid) state_next = fac_pkg::S_DISPATCH;
      fac_pkg::S_DISPATCH: begin
        unique case (stat.op)
          fac_pkg::OP_ALLOC:
            state_next = stat.req_zero ? fac_pkg::S_DONE : fac_pkg::S_A_SCAN;
          fac_pkg::OP_FREE:  state_next = fac_pkg::S_F_SCAN;
          fac_pkg::OP_TERM:  state_next = fac_pkg::S_T_CNT;
          default:           state_next = fac_pkg::S_DONE;
        endcase
      end
      fac_pkg::S_A_SCAN:
        if (stat.f_end || (stat.fit && !stat.pick_ok && !stat.fit_mode))
          state_next = fac_pkg::S_A_END;
      fac_pkg::S_A_END:
        state_next = (!stat.pick_ok || stat.ufull) ? fac_pkg::S_DONE : fac_pkg::S_A_WRITE;
      fac_pkg::S_A_WRITE: state_next = fac_pkg::S_DONE;
      fac_pkg::S_F_SCAN:
        if (stat.u_end)        state_next = fac_pkg::S_DONE;
        else if (stat.u_match) state_next = fac_pkg::S_F_CHK;
      fac_pkg::S_F_CHK:
        state_next = stat.ffull ? fac_pkg::S_DONE : fac_pkg::S_I_SCAN;
      fac_pkg::S_I_SCAN:
        if (stat.f_end || stat.ins_here)
          state_next = (stat.op == fac_pkg::OP_TERM) ? fac_pkg::S_T_LOOP : fac_pkg::S_M_START;
      fac_pkg::S_T_CNT:  if (stat.u_end) state_next = fac_pkg::S_T_CHK;
      fac_pkg::S_T_CHK:
        state_next = (stat.k_zero || stat.t_over) ? fac_pkg::S_DONE : fac_pkg::S_T_LOOP;
      fac_pkg::S_T_LOOP:
        if (stat.u_end)        state_next = fac_pkg::S_M_START;
        else if (stat.o_match) state_next = fac_pkg::S_I_SCAN;
      fac_pkg::S_M_START: state_next = fac_pkg::S_M_LOAD;
      fac_pkg::S_M_LOAD:
        if (stat.m_end) state_next = stat.changed ? fac_pkg::S_M_START : fac_pkg::S_DONE;
        else            state_next = fac_pkg::S_M_STEP;
      fac_pkg::S_M_STEP: state_next = fac_pkg::S_M_LOAD;
      fac_pkg::S_DONE:   if (stat.out_free) state_next = fac_pkg::S_IDLE;
      default:           state_next = fac_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = fac_pkg::C_NOP;
    cmd.code = fac_pkg::ST_OK;
    unique case (state)
      fac_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = fac_pkg::C_LOAD;
      end
      fac_pkg::S_DISPATCH: begin
        unique case (stat.op)
          fac_pkg::OP_ALLOC: begin
            cmd.op   = stat.req_zero ? fac_pkg::C_STATUS : fac_pkg::C_ASTART;
            cmd.code = fac_pkg::ST_NO_SPACE;
          end
          fac_pkg::OP_FREE, fac_pkg::OP_TERM: cmd.op = fac_pkg::C_USTART;
          default: ;
        endcase
      end
      fac_pkg::S_A_SCAN: if (!stat.f_end) cmd.op = fac_pkg::C_ASCAN;
      fac_pkg::S_A_END: begin
        if (!stat.pick_ok) begin
          cmd.op   = fac_pkg::C_STATUS;
          cmd.code = fac_pkg::ST_NO_SPACE;
        end else if (stat.ufull) begin
          cmd.op   = fac_pkg::C_STATUS;
          cmd.code = fac_pkg::ST_FULL;
        end else begin
          cmd.op = fac_pkg::C_APICK;
        end
      end
      fac_pkg::S_A_WRITE: cmd.op = fac_pkg::C_AWRITE;
      fac_pkg::S_F_SCAN: begin
        if (stat.u_end) begin
          cmd.op   = fac_pkg::C_STATUS;
          cmd.code = fac_pkg::ST_NOT_FOUND;
        end else if (!stat.u_match) begin
          cmd.op = fac_pkg::C_USKIP;
        end
      end
      fac_pkg::S_F_CHK: begin
        cmd.op   = stat.ffull ? fac_pkg::C_STATUS : fac_pkg::C_TAKE;
        cmd.code = fac_pkg::ST_FULL;
      end
      fac_pkg::S_I_SCAN:
        cmd.op = (stat.f_end || stat.ins_here) ? fac_pkg::C_IWRITE : fac_pkg::C_FSKIP;
      fac_pkg::S_T_CNT: if (!stat.u_end) cmd.op = fac_pkg::C_TCNT;
      fac_pkg::S_T_CHK: begin
        if (stat.k_zero) begin
          cmd.op   = fac_pkg::C_STATUS;
          cmd.code = fac_pkg::ST_NOT_FOUND;
        end else if (stat.t_over) begin
          cmd.op   = fac_pkg::C_STATUS;
          cmd.code = fac_pkg::ST_FULL;
        end else begin
          cmd.op = fac_pkg::C_USTART;
        end
      end
      fac_pkg::S_T_LOOP:
        if (!stat.u_end) cmd.op = stat.o_match ? fac_pkg::C_TAKE : fac_pkg::C_USKIP;
      fac_pkg::S_M_START: cmd.op = fac_pkg::C_MSTART;
      fac_pkg::S_M_LOAD:  if (!stat.m_end) cmd.op = fac_pkg::C_MLOAD;
      fac_pkg::S_M_STEP:  cmd.op = fac_pkg::C_MSTEP;
      fac_pkg::S_DONE:    if (stat.out_free) cmd.op = fac_pkg::C_OUT;
      default: ;
    endcase
  end

endmodule

@@ src/fac_chk.sv @@
// fac_chk.sv: port-level checker for the fit allocator, bound to the top level
`timescale 1ns / 1ps
module fac_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input fac_pkg::out_item_t out_item,
  input logic               out_valid,
  input logic               out_ready
);

  // one item in flight: after an accept the input side is closed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in flight");

  // a failed item returns no address and no bytes
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != fac_pkg::ST_OK |->
      out_item.granted_address == 24'd0 && out_item.freed_bytes == 25'd0)
    else $error("error result carries data");

  // an allocate never frees
  a_grant_no_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.granted_address != 24'd0 |-> out_item.freed_bytes == 25'd0)
    else $error("grant and free in one result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed under stall");

endmodule

bind fit_allocator_with_coalesce_unit fac_chk u_fac_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

@@ test/tb_fit_allocator_with_coalesce_unit.sv @@
// tb_fit_allocator_with_coalesce_unit.sv: self-checking testbench of the fit allocator
`timescale 1ns / 1ps
module tb_fit_allocator_with_coalesce_unit;

  localparam int unsigned ADDR_MAX = 32'hFFFFFF;
  localparam int unsigned REQ_MAX  = 32'h1000000;
  localparam int WATCHDOG   = 50000;
  localparam int DIR_ROWS   = 18;
  localparam int PHASES     = 5;
  localparam int PHASE_ITEMS = 260;
  localparam int FREE_N     = fac_pkg::FREE_ENTRIES;
  localparam int USED_N     = fac_pkg::USED_ENTRIES;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready, cfg_index;
  logic [24:0] cfg_data;
  fac_pkg::in_item_t  in_item;
  fac_pkg::out_item_t out_item;

  fit_allocator_with_coalesce_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shadow copy of the allocator state
  logic        best_fit;
  int unsigned coalesce_limit;
  int unsigned fl_start [FREE_N];
  int unsigned fl_len   [FREE_N];
  int unsigned fl_n;
  int unsigned ul_start [USED_N];
  int unsigned ul_len   [USED_N];
  int unsigned ul_owner [USED_N];
  int unsigned ul_tag   [USED_N];
  int unsigned ul_n;

  fac_pkg::out_item_t pending_results [$];
  int        mismatches;
  int        idle_cycles;

  // directed stimulus table
  typedef struct {
    fac_pkg::op_t     op;
    logic [7:0]       owner;
    logic [7:0]       tag;
    logic [24:0]      req;
    bit               typed;      // expected result given below, else predicted
    fac_pkg::status_t st;
    logic [23:0]      addr;
    logic [24:0]      freed;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS];

  // config settings walked phase by phase, extremes included
  logic        phase_fit [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  logic [24:0] phase_lim [PHASES] = '{25'd4194304, 25'd16777216, 25'd0, 25'd1048577,
                                      25'd2097152};

  function automatic void free_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fl_n; i++) begin
      fl_start[i] = fl_start[i + 1];
      fl_len[i]   = fl_len[i + 1];
    end
    fl_n--;
  endfunction

  function automatic void free_put(int unsigned start, int unsigned len);
    int unsigned pos;
    pos = 0;
    if (fl_n >= FREE_N) return;
    while (pos < fl_n && !(fl_start[pos] > start)) pos++;
    for (int unsigned i = fl_n; i > pos; i--) begin
      fl_start[i] = fl_start[i - 1];
      fl_len[i]   = fl_len[i - 1];
    end
    fl_start[pos] = start & ADDR_MAX;
    fl_len[pos]   = len & ADDR_MAX;
    fl_n++;
  endfunction

  function automatic void used_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < ul_n; i++) begin
      ul_start[i] = ul_start[i + 1];
      ul_len[i]   = ul_len[i + 1];
      ul_owner[i] = ul_owner[i + 1];
      ul_tag[i]   = ul_tag[i + 1];
    end
    ul_n--;
  endfunction

  // merge passes: pair i with i+1, after a merge skip past the pair
  function automatic void coalesce();
    bit changed;
    int unsigned i, sum;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      i = 0;
      while (i + 1 < fl_n) begin
        sum = fl_len[i] + fl_len[i + 1];
        if (fl_start[i] + fl_len[i] == fl_start[i + 1] && sum < coalesce_limit &&
            sum <= ADDR_MAX) begin
          fl_len[i] = sum;
          free_drop(i + 1);
          changed = 1'b1;
        end
        i++;
      end
    end
  endfunction

  // applies one item to the shadow state and returns the result it causes
  function automatic fac_pkg::out_item_t allocator_result(fac_pkg::in_item_t it);
    fac_pkg::out_item_t r;
    int unsigned pick, hit, cnt, i, req;
    r = '0;
    req = it.request_bytes;
    case (fac_pkg::op_t'(it.operation))
      fac_pkg::OP_ALLOC: begin
        pick = FREE_N;
        for (i = 0; i < fl_n && req != 0; i++) begin
          if (fl_len[i] >= req) begin
            if (pick == FREE_N) begin
              pick = i;
              if (!best_fit) break;
            end else if (fl_len[i] < fl_len[pick]) begin
              pick = i;
            end
          end
        end
        if (pick == FREE_N) r.status = fac_pkg::ST_NO_SPACE;
        else if (ul_n >= USED_N) r.status = fac_pkg::ST_FULL;
        else begin
          r.granted_address = 24'(fl_start[pick]);
          ul_start[ul_n] = fl_start[pick];
          ul_len[ul_n]   = req & ADDR_MAX;
          ul_owner[ul_n] = it.owner_id;
          ul_tag[ul_n]   = it.block_tag;
          ul_n++;
          fl_start[pick] = (fl_start[pick] + req) & ADDR_MAX;
          fl_len[pick]  -= req;
          if (fl_len[pick] == 0) free_drop(pick);
        end
      end
      fac_pkg::OP_FREE: begin
        hit = USED_N;
        for (i = 0; i < ul_n; i++) begin
          if (ul_owner[i] == it.owner_id && ul_tag[i] == it.block_tag) begin
            hit = i;
            break;
          end
        end
        if (hit == USED_N) r.status = fac_pkg::ST_NOT_FOUND;
        else if (fl_n >= FREE_N) r.status = fac_pkg::ST_FULL;
        else begin
          r.freed_bytes = 25'(ul_len[hit]);
          free_put(ul_start[hit], ul_len[hit]);
          used_drop(hit);
          coalesce();
        end
      end
      fac_pkg::OP_TERM: begin
        cnt = 0;
        for (i = 0; i < ul_n; i++) if (ul_owner[i] == it.owner_id) cnt++;
        if (cnt == 0) r.status = fac_pkg::ST_NOT_FOUND;
        else if (fl_n + cnt > FREE_N) r.status = fac_pkg::ST_FULL;
        else begin
          i = 0;
          while (i < ul_n) begin
            if (ul_owner[i] == it.owner_id) begin
              r.freed_bytes = 25'(r.freed_bytes + ul_len[i]);
              free_put(ul_start[i], ul_len[i]);
              used_drop(i);
            end else begin
              i++;
            end
          end
          coalesce();
        end
      end
      default: ;  // reserved code: no change, zero result
    endcase
    return r;
  endfunction

  // random item, mostly frees of live blocks and plausible allocations
  function automatic fac_pkg::in_item_t random_item();
    fac_pkg::in_item_t it;
    int unsigned sel, k;
    it.owner_id      = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    it.block_tag     = 8'($urandom);
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.request_bytes = 25'($urandom_range(1, 4096));
      5, 6:          it.request_bytes = 25'($urandom_range(1, 1048576));
      7:             it.request_bytes = 25'($urandom_range(1, REQ_MAX));
      8:             it.request_bytes = (fl_n > 0) ?
                       25'(fl_len[$urandom_range(0, fl_n - 1)]) : 25'd1;
      default:       it.request_bytes = ($urandom_range(0, 3) == 0) ? 25'd0 :
                       25'($urandom_range(0, REQ_MAX));
    endcase
    if (sel < 47) begin
      it.operation = fac_pkg::OP_ALLOC;
    end else if (sel < 85) begin
      it.operation = fac_pkg::OP_FREE;
      if (ul_n > 0 && $urandom_range(0, 7) != 0) begin
        k = $urandom_range(0, ul_n - 1);
        it.owner_id  = 8'(ul_owner[k]);
        it.block_tag = 8'(ul_tag[k]);
      end
    end else if (sel < 97) begin
      it.operation = fac_pkg::OP_TERM;
      if (ul_n > 0 && $urandom_range(0, 4) != 0)
        it.owner_id = 8'(ul_owner[$urandom_range(0, ul_n - 1)]);
    end else begin
      it.operation = fac_pkg::OP_RSVD;
    end
    return it;
  endfunction

  // sender: random gap, then hold the item until accepted
  task automatic send_item(fac_pkg::in_item_t it, bit typed, fac_pkg::out_item_t typed_res);
    int gap;
    fac_pkg::out_item_t predicted;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = allocator_result(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // both registers back to back, valid held across the pair
  task automatic write_config(logic fit, logic [24:0] lim);
    cfg_index <= fac_pkg::CFG_FIT_MODE;
    cfg_data  <= 25'(fit);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    best_fit = fit;
    cfg_index <= fac_pkg::CFG_MERGE_LIMIT;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    coalesce_limit = lim;
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until all results are back, plus a margin for the unit to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: random stall per item, check against the oldest expectation
  initial begin : result_side
    int stall;
    fac_pkg::out_item_t want;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d addr %h freed %h",
                   out_item.status, out_item.granted_address, out_item.freed_bytes);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status ||
            out_item.granted_address !== want.granted_address ||
            out_item.freed_bytes !== want.freed_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d addr %h freed %h, got %0d %h %h",
                     want.status, want.granted_address, want.freed_bytes,
                     out_item.status, out_item.granted_address, out_item.freed_bytes);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    fac_pkg::in_item_t it;
    fac_pkg::out_item_t typed_res;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= fac_pkg::CFG_FIT_MODE;
    cfg_data  <= '0;

    // reset state of the shadow tables
    best_fit       = 1'b0;
    coalesce_limit = fac_pkg::MERGE_LIMIT_RST;
    fl_n = fac_pkg::RST_REGIONS;
    ul_n = 0;
    for (int i = 0; i < fac_pkg::RST_REGIONS; i++) begin
      fl_start[i] = fac_pkg::RST_START[i];
      fl_len[i]   = fac_pkg::RST_LEN[i];
    end

    // zero request, oversize, region exhausted and freed, missing block,
    // missing owner, reserved code, oversize, then predicted extremes and frees
    dir_tab = '{
      '{fac_pkg::OP_ALLOC, 8'd0, 8'd0, 25'd0, 1'b1, fac_pkg::ST_NO_SPACE, 24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd0, 8'd0, 25'd16777216, 1'b1, fac_pkg::ST_NO_SPACE,
        24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd1, 8'd1, 25'd1048576, 1'b1, fac_pkg::ST_OK,
        24'h300000, 25'd0},
      '{fac_pkg::OP_FREE, 8'd1, 8'd1, 25'd0, 1'b1, fac_pkg::ST_OK, 24'd0, 25'd1048576},
      '{fac_pkg::OP_FREE, 8'd7, 8'd7, 25'd5, 1'b1, fac_pkg::ST_NOT_FOUND, 24'd0, 25'd0},
      '{fac_pkg::OP_TERM, 8'd9, 8'd0, 25'd5, 1'b1, fac_pkg::ST_NOT_FOUND, 24'd0, 25'd0},
      '{fac_pkg::OP_RSVD, 8'd255, 8'd255, 25'd16777216, 1'b1, fac_pkg::ST_OK,
        24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd3, 8'd3, 25'd16777215, 1'b1, fac_pkg::ST_NO_SPACE,
        24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd255, 8'd255, 25'd8388608, 1'b0, fac_pkg::ST_OK,
        24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd0, 8'd0, 25'd1, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd2, 8'd3, 25'd4, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd2, 8'd4, 25'd100, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0},
      '{fac_pkg::OP_TERM, 8'd2, 8'd0, 25'd0, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0},
      '{fac_pkg::OP_FREE, 8'd255, 8'd255, 25'd0, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd170, 8'd85, 25'h0055555, 1'b0, fac_pkg::ST_OK,
        24'd0, 25'd0},
      '{fac_pkg::OP_ALLOC, 8'd85, 8'd170, 25'h0AAAAA, 1'b0, fac_pkg::ST_OK,
        24'd0, 25'd0},
      '{fac_pkg::OP_FREE, 8'd170, 8'd85, 25'd0, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0},
      '{fac_pkg::OP_TERM, 8'd85, 8'd0, 25'd0, 1'b0, fac_pkg::ST_OK, 24'd0, 25'd0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset configuration
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.operation     = dir_tab[r].op;
      it.owner_id      = dir_tab[r].owner;
      it.block_tag     = dir_tab[r].tag;
      it.request_bytes = dir_tab[r].req;
      typed_res.status          = dir_tab[r].st;
      typed_res.granted_address = dir_tab[r].addr;
      typed_res.freed_bytes     = dir_tab[r].freed;
      send_item(it, dir_tab[r].typed, typed_res);
    end

    // random phases, each under its own setting; the unit is idle at each switch
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_config(phase_fit[p], phase_lim[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        send_item(it, 1'b0, typed_res);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fac_pkg.sv
src/fac_dp.sv
src/fac_ctrl.sv
src/fit_allocator_with_coalesce_unit.sv
src/fac_chk.sv
test/tb_fit_allocator_with_coalesce_unit.sv
